[design/typed_frame_string_extractor_defines.svh]
// assertion macros for the frame string extractor checker
`ifndef TYPED_FRAME_STRING_EXTRACTOR_DEFINES_SVH
`define TYPED_FRAME_STRING_EXTRACTOR_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define TFSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define TFSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[design/tfse_pkg.sv]
// package of the frame string extractor: constants and types
`default_nettype none
package tfse_pkg;
  localparam int unsigned BufferDepthDef = 4096;
  localparam int unsigned MinTotal = 6;

  typedef enum logic [2:0] {
    CfgHead  = 3'd0,
    CfgTail  = 3'd1,
    CfgStr   = 3'd2,
    CfgShort = 3'd3,
    CfgWord  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StRd0,
    StRd1,
    StRd2,
    StRd3,
    StRd4,
    StRd5,
    StHunt,
    StWait,
    StWalk,
    StWalkStr,
    StString,
    StOut
  } state_e;
endpackage
`default_nettype wire

[design/typed_frame_string_extractor.sv]
// Frame string extractor top level: ring buffer memory and engine sequencer.
// A new item is accepted only while the sequencer is idle and no result is
// pending. The ring memory has one read port, so each buffer byte needed by
// an engine step is fetched by its own registered read.
// Reset (async, active low) clears pointers, count, step, phase, lengths,
// config, result-valid; output flags and ring stay undefined until written.
`default_nettype none
module typed_frame_string_extractor #(
  parameter int unsigned BUFFER_DEPTH = tfse_pkg::BufferDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             byte_present_o,
  output logic             string_last_o,
  output logic             frame_done_o,
  output logic             oversize_drop_o,
  output logic             buffer_full_o
);
  import tfse_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(BUFFER_DEPTH);
  localparam logic [16:0] DepthL = 17'(BUFFER_DEPTH);

  logic [7:0] mem_q [BUFFER_DEPTH];
  logic [7:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;

  logic [15:0] head_q, tail_q, stag_q, shtag_q, wtag_q;
  logic [AW-1:0] wp_q, wp_d, sp_q, sp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0] flen_q, flen_d, cur_q, cur_d, srem_q, srem_d;
  state_e st_q, st_d, ph_q, ph_d;
  logic [7:0] b_q [6];
  logic [7:0] b_d [6];
  logic [7:0] byte_q, byte_d;
  logic       ov_q, ov_d, bp_q, bp_d, sl_q, sl_d, fd_q, fd_d, od_q, od_d, bf_q, bf_d;
  logic       rv_q, rv_d;

  // ring memory: one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wp_q] <= data_byte_i;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; tail_q <= '0; stag_q <= '0; shtag_q <= '0; wtag_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHead:  head_q <= cfg_data_i;
        CfgTail:  tail_q <= cfg_data_i;
        CfgStr:   stag_q <= cfg_data_i;
        CfgShort: shtag_q <= cfg_data_i;
        CfgWord:  wtag_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [15:0] be01, be23, be45;
  assign be01 = {b_q[0], b_q[1]};
  assign be23 = {b_q[2], b_q[3]};
  assign be45 = {b_q[4], b_q[5]};

  // base offset (from scan pointer) of reads for the current engine phase
  logic [15:0] base;
  logic [2:0]  nrd;
  logic [2:0]  ridx;
  logic [15:0] end_l;
  logic [16:0] c2, c4, c6, c6s;
  assign end_l = flen_q - 16'd2;
  assign c2 = {1'b0, cur_q} + 17'd2;
  assign c4 = {1'b0, cur_q} + 17'd4;
  assign c6 = {1'b0, cur_q} + 17'd6;
  assign c6s = c6 + {1'b0, be45};

  always_comb begin
    base = '0;
    nrd = 3'd0;
    unique case (ph_q)
      StHunt:   begin base = '0; nrd = 3'd4; end
      StWait:   begin base = flen_q - 16'd2; nrd = 3'd2; end
      StWalk:   begin base = cur_q; nrd = 3'd6; end
      StString: begin base = cur_q; nrd = 3'd1; end
      default:  begin base = '0; nrd = 3'd0; end
    endcase
  end

  always_comb begin
    unique case (st_q)
      StRd1: ridx = 3'd1;
      StRd2: ridx = 3'd2;
      StRd3: ridx = 3'd3;
      StRd4: ridx = 3'd4;
      StRd5: ridx = 3'd5;
      default: ridx = 3'd0;
    endcase
  end
  assign rd_addr = sp_q + AW'(base) + AW'(ridx);

  assign in_ready_o = (st_q == StIdle) && !rv_q;
  assign wr_en = in_valid_i && in_ready_o && !req_type_i && (cnt_q < DepthC);

  always_comb begin
    st_d = st_q; ph_d = ph_q; wp_d = wp_q; sp_d = sp_q; cnt_d = cnt_q;
    flen_d = flen_q; cur_d = cur_q; srem_d = srem_q;
    b_d = b_q;
    byte_d = byte_q; ov_d = ov_q; bp_d = bp_q; sl_d = sl_q; fd_d = fd_q;
    od_d = od_q; bf_d = bf_q; rv_d = rv_q;
    rd_en = 1'b0;
    if (rv_q && res_ready_i) rv_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          byte_d = '0; ov_d = 1'b0; bp_d = 1'b0; sl_d = 1'b0; fd_d = 1'b0;
          od_d = 1'b0; bf_d = 1'b0;
          if (!req_type_i) begin
            if (cnt_q >= DepthC) bf_d = 1'b1;
            else begin
              wp_d = wp_q + AW'(1);
              cnt_d = cnt_q + CW'(1);
            end
          end
          st_d = StRd0;
        end
      end
      StRd0, StRd1, StRd2, StRd3, StRd4, StRd5: begin
        // at most one read issued per step; its data is captured in the next step
        if (st_q != StRd0) b_d[ridx - 3'd1] = rd_q;
        if (({1'b0, ridx} < {1'b0, nrd}) && !((ph_q == StHunt) && (cnt_q < CW'(MinTotal)))
            && !((ph_q == StWait) && ({{(17-CW){1'b0}}, cnt_q} < {1'b0, flen_q}))) begin
          rd_en = 1'b1;
          unique case (st_q)
            StRd0: st_d = StRd1;
            StRd1: st_d = StRd2;
            StRd2: st_d = StRd3;
            StRd3: st_d = StRd4;
            StRd4: st_d = StRd5;
            default: st_d = StHunt;
          endcase
        end else begin
          st_d = StHunt;
        end
        if (st_q == StRd5 && ({1'b0, ridx} >= {1'b0, nrd})) st_d = StHunt;
        if (st_q == StRd5 && rd_en) st_d = StWalkStr;
      end
      StWalkStr: begin
        b_d[5] = rd_q;
        st_d = StHunt;
      end
      StHunt: begin
        st_d = StOut;
        unique case (ph_q)
          StHunt: begin
            if (cnt_q >= CW'(MinTotal)) begin
              if (be01 != head_q) begin
                sp_d = sp_q + AW'(1); cnt_d = cnt_q - CW'(1);
              end else if (be23 < 16'(MinTotal) || {1'b0, be23} > DepthL) begin
                od_d = 1'b1;
                sp_d = sp_q + AW'(1); cnt_d = cnt_q - CW'(1);
              end else begin
                flen_d = be23; ph_d = StWait;
              end
            end
          end
          StWait: begin
            if ({{(17-CW){1'b0}}, cnt_q} >= {1'b0, flen_q}) begin
              if (be01 != tail_q) begin
                sp_d = sp_q + AW'(2); cnt_d = cnt_q - CW'(2); ph_d = StHunt;
              end else begin
                cur_d = 16'd4; ph_d = StWalk;
              end
            end
          end
          StWalk: begin
            if (c2 > {1'b0, end_l}) fd_d = 1'b1;
            else if (be01 == stag_q) begin
              if (!(c4 <= {1'b0, end_l} && be23 == shtag_q)) fd_d = 1'b1;
              else if (c6 > {1'b0, end_l}) fd_d = 1'b1;
              else if (c6s > {1'b0, end_l}) fd_d = 1'b1;
              else begin
                cur_d = c6[15:0];
                if (be45 == 16'd0) begin
                  ov_d = 1'b1; sl_d = 1'b1;
                end else begin
                  srem_d = be45; ph_d = StString;
                end
              end
            end else if (be01 == wtag_q) begin
              if (c6 > {1'b0, end_l}) fd_d = 1'b1;
              else cur_d = c6[15:0];
            end else if (be01 == shtag_q) begin
              if (c4 > {1'b0, end_l}) fd_d = 1'b1;
              else cur_d = c4[15:0];
            end else fd_d = 1'b1;
            if (fd_d) begin
              sp_d = sp_q + AW'(flen_q);
              cnt_d = cnt_q - CW'(flen_q);
              ph_d = StHunt;
            end
          end
          StString: begin
            ov_d = 1'b1; byte_d = b_q[0]; bp_d = 1'b1;
            cur_d = cur_q + 16'd1;
            srem_d = srem_q - 16'd1;
            if (srem_q == 16'd1) begin
              sl_d = 1'b1; ph_d = StWalk;
            end
          end
          default: ph_d = StHunt;
        endcase
      end
      StOut: begin
        if (ov_q || fd_q || od_q || bf_q) rv_d = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ph_q <= StHunt; wp_q <= '0; sp_q <= '0; cnt_q <= '0;
      flen_q <= '0; cur_q <= '0; srem_q <= '0; rv_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; wp_q <= wp_d; sp_q <= sp_d; cnt_q <= cnt_d;
      flen_q <= flen_d; cur_q <= cur_d; srem_q <= srem_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;
    byte_q <= byte_d; ov_q <= ov_d; bp_q <= bp_d; sl_q <= sl_d; fd_q <= fd_d;
    od_q <= od_d; bf_q <= bf_d;
  end

  assign res_valid_o = rv_q;
  assign out_valid_o = ov_q;
  assign out_byte_o = byte_q;
  assign byte_present_o = bp_q;
  assign string_last_o = sl_q;
  assign frame_done_o = fd_q;
  assign oversize_drop_o = od_q;
  assign buffer_full_o = bf_q;
endmodule
`default_nettype wire

[design/tfse_checker.sv]
// port-level checker for the frame string extractor, bound to the top level
`default_nettype none
`include "typed_frame_string_extractor_defines.svh"
module tfse_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic res_valid_o,
  input wire logic res_ready_i,
  input wire logic out_valid_o,
  input wire logic byte_present_o,
  input wire logic string_last_o,
  input wire logic frame_done_o,
  input wire logic oversize_drop_o,
  input wire logic buffer_full_o
);
  `TFSE_ASSERT_IMP(a_res_flag, clk_i, rst_ni, res_valid_o, out_valid_o || frame_done_o || oversize_drop_o || buffer_full_o)
  `TFSE_ASSERT_IMP(a_byte_evt, clk_i, rst_ni, res_valid_o && byte_present_o, out_valid_o)
  `TFSE_ASSERT_IMP(a_empty_last, clk_i, rst_ni, res_valid_o && out_valid_o && !byte_present_o, string_last_o)
  `TFSE_ASSERT_NXT(a_hold, clk_i, rst_ni, res_valid_o && !res_ready_i, res_valid_o)
  `TFSE_ASSERT_NXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
endmodule

bind typed_frame_string_extractor tfse_checker u_tfse_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .res_valid_o(res_valid_o), .res_ready_i(res_ready_i), .out_valid_o(out_valid_o),
  .byte_present_o(byte_present_o), .string_last_o(string_last_o),
  .frame_done_o(frame_done_o), .oversize_drop_o(oversize_drop_o),
  .buffer_full_o(buffer_full_o)
);
`default_nettype wire
